// ===== rtl/core/hatch_span_mask_generator_assert.svh =====
// Assertion macros used by the hatch span mask generator RTL.
`ifndef HATCH_SPAN_MASK_GENERATOR_ASSERT_SVH
`define HATCH_SPAN_MASK_GENERATOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HSMG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HSMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hsmg_pkg.sv =====
// Types and constants of the hatch span mask generator.
package hsmg_pkg;

    localparam int X_W          = 12;
    localparam int D_W          = 11;
    localparam int MASK_W       = 64;
    localparam int WORD_W       = 6;
    localparam int MARK_W       = 13;
    localparam int SCREEN_WIDTH = 4096;
    localparam int MOD_STEPS    = 12;
    localparam int CNT_W        = 4;

    localparam logic [X_W-1:0]    X_MAX         = X_W'(SCREEN_WIDTH - 1);
    localparam logic [D_W-1:0]    SPACING_RESET = D_W'(8);
    localparam logic [MARK_W-1:0] MARK_NONE     = '1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MODS  = 7'b0000010,
        ST_HOFF  = 7'b0000100,
        ST_HNEG  = 7'b0001000,
        ST_MODL  = 7'b0010000,
        ST_FIRST = 7'b0100000,
        ST_WALK  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic           start;
        logic [X_W-1:0] dividend;
        logic [X_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic           done;
        logic [X_W-1:0] rem;
    } t_mod_rsp;

endpackage

// ===== rtl/core/hsmg_span_if.sv =====
// Channel that carries one span per transfer.
interface hsmg_span_if;
    logic                      valid;
    logic                      ready;
    logic [hsmg_pkg::X_W-1:0] x_left;
    logic [hsmg_pkg::X_W-1:0] x_right;
    logic [hsmg_pkg::X_W-1:0] scan_line;

    modport source (output valid, output x_left, output x_right, output scan_line,
                    input ready);
    modport sink (input valid, input x_left, input x_right, input scan_line,
                  output ready);
endinterface

// ===== rtl/core/hsmg_word_if.sv =====
// Channel that carries one mask word per transfer.
interface hsmg_word_if;
    logic                         valid;
    logic                         ready;
    logic [hsmg_pkg::X_W-1:0]    word_base_x;
    logic [hsmg_pkg::MASK_W-1:0] pixel_mask;
    logic [hsmg_pkg::X_W-1:0]    line_echo;
    logic                         last_word;

    modport source (output valid, output word_base_x, output pixel_mask,
                    output line_echo, output last_word, input ready);
    modport sink (input valid, input word_base_x, input pixel_mask,
                  input line_echo, input last_word, output ready);
endinterface

// ===== rtl/core/hsmg_cfg_if.sv =====
// Write channel of the hatch spacing register.
interface hsmg_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [hsmg_pkg::D_W-1:0] hatch_spacing;

    modport source (output valid, output hatch_spacing, input ready);
    modport sink (input valid, input hatch_spacing, output ready);
endinterface

// ===== rtl/core/hsmg_mod_unit.sv =====
// Serial remainder unit that resolves one dividend bit per cycle.
module hsmg_mod_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsmg_pkg::t_mod_req  i_req,
    output hsmg_pkg::t_mod_rsp  o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [hsmg_pkg::CNT_W-1:0]    r_cnt;
    logic [hsmg_pkg::X_W-1:0]      r_num;
    logic [hsmg_pkg::X_W-1:0]      r_rem;
    logic [hsmg_pkg::X_W:0]        trial;
    logic [hsmg_pkg::X_W-1:0]      n_rem;

    always_comb begin
        trial = {r_rem, r_num[hsmg_pkg::X_W-1]};
        if (trial >= {1'b0, i_req.divisor}) begin
            n_rem = hsmg_pkg::X_W'(trial - {1'b0, i_req.divisor});
        end else begin
            n_rem = trial[hsmg_pkg::X_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= hsmg_pkg::CNT_W'(hsmg_pkg::MOD_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - hsmg_pkg::CNT_W'(1);
            if (r_cnt == hsmg_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[hsmg_pkg::X_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/core/hatch_span_mask_generator.sv =====
// Top level of the hatch span mask generator.
//
// A span (x_left, x_right, scan_line) enters on i_span and yields one
// 64-pixel mask word per aligned word from the word of x_left to the word
// of x_right, on o_word; the last word of a span carries last_word.
// A span with x_left greater than x_right yields no words.
// The hatch spacing is written on i_cfg, which is always ready; write it
// only while no span is in progress.
// i_span is ready only while no span is in progress. With a nonzero spacing
// a span's setup is dominated by two passes through the serial remainder
// unit, then the walk sets each hatch point inside the span and hands out
// each mask word in turn. With zero spacing the setup skips both passes.
// An empty span is absorbed in its transfer cycle.
// A finished word waits in the output register; while o_word is stalled the
// walk sets the points of its word, then holds until the register empties.
// Reset returns the block to idle, empties the output register and sets the
// spacing to 8.
module hatch_span_mask_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsmg_span_if.sink     i_span,
    hsmg_cfg_if.sink      i_cfg,
    hsmg_word_if.source   o_word
);

    `include "hatch_span_mask_generator_assert.svh"

    hsmg_pkg::t_state                r_state, n_state;
    logic [hsmg_pkg::D_W-1:0]        r_d;
    logic [hsmg_pkg::X_W-1:0]        r_t, n_t;
    logic [hsmg_pkg::X_W-1:0]        r_left, n_left;
    logic [hsmg_pkg::X_W-1:0]        r_right, n_right;
    logic [hsmg_pkg::X_W-1:0]        r_scan, n_scan;
    logic [hsmg_pkg::D_W-1:0]        r_h, n_h;
    logic [hsmg_pkg::X_W-1:0]        r_hn, n_hn;
    logic [hsmg_pkg::X_W-1:0]        r_step_ab, n_step_ab;
    logic [hsmg_pkg::X_W-1:0]        r_step_ba, n_step_ba;
    logic [hsmg_pkg::MARK_W-1:0]     r_mark, n_mark;
    logic                            r_phase, n_phase;
    logic [hsmg_pkg::WORD_W-1:0]     r_word, n_word;
    logic [hsmg_pkg::MASK_W-1:0]     r_mask, n_mask;
    logic                            r_out_valid, n_out_valid;
    logic [hsmg_pkg::X_W-1:0]        r_out_base, n_out_base;
    logic [hsmg_pkg::MASK_W-1:0]     r_out_mask, n_out_mask;
    logic [hsmg_pkg::X_W-1:0]        r_out_line, n_out_line;
    logic                            r_out_last, n_out_last;

    hsmg_pkg::t_mod_req              mod_req;
    hsmg_pkg::t_mod_rsp              mod_rsp;

    logic                            span_xfer;
    logic [hsmg_pkg::X_W-1:0]        right_clip;
    logic                            out_free;
    logic [hsmg_pkg::X_W-1:0]        dist_a;
    logic [hsmg_pkg::X_W-1:0]        h_ext;
    logic [hsmg_pkg::X_W-1:0]        hn_calc;
    logic [hsmg_pkg::X_W-1:0]        hdiff;
    logic [hsmg_pkg::X_W-1:0]        base0;
    logic                            hit;
    logic [hsmg_pkg::X_W-1:0]        step_sel;
    logic                            is_last;

    hsmg_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign i_span.ready = (r_state == hsmg_pkg::ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign span_xfer    = i_span.valid && i_span.ready;
    assign right_clip   = (i_span.x_right > hsmg_pkg::X_MAX) ? hsmg_pkg::X_MAX
                                                              : i_span.x_right;
    assign out_free     = !r_out_valid || o_word.ready;

    assign h_ext   = {1'b0, r_h};
    assign dist_a  = (mod_rsp.rem >= {1'b0, r_d}) ? (mod_rsp.rem - {1'b0, r_d})
                                                    : ({1'b0, r_d} - mod_rsp.rem);
    assign hn_calc = (r_h == '0) ? '0 : (r_t - h_ext);
    assign hdiff   = hn_calc - h_ext;
    assign base0   = r_left - mod_rsp.rem;
    assign hit     = (r_mark <= {1'b0, r_right})
                  && (r_mark[hsmg_pkg::MARK_W-1:hsmg_pkg::WORD_W] == {1'b0, r_word});
    assign step_sel = r_phase ? r_step_ba : r_step_ab;
    assign is_last  = (r_word == r_right[hsmg_pkg::X_W-1:hsmg_pkg::WORD_W]);

    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_left      = r_left;
        n_right     = r_right;
        n_scan      = r_scan;
        n_h         = r_h;
        n_hn        = r_hn;
        n_step_ab   = r_step_ab;
        n_step_ba   = r_step_ba;
        n_mark      = r_mark;
        n_phase     = r_phase;
        n_word      = r_word;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !o_word.ready;
        n_out_base  = r_out_base;
        n_out_mask  = r_out_mask;
        n_out_line  = r_out_line;
        n_out_last  = r_out_last;
        mod_req.start    = 1'b0;
        mod_req.dividend = r_left;
        mod_req.divisor  = r_t;

        unique case (r_state)
            hsmg_pkg::ST_IDLE: begin
                if (span_xfer && (i_span.x_left <= right_clip)) begin
                    n_t     = {r_d, 1'b0};
                    n_left  = i_span.x_left;
                    n_right = right_clip;
                    n_scan  = i_span.scan_line;
                    if (r_d == '0) begin
                        n_state = hsmg_pkg::ST_FIRST;
                    end else begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = i_span.scan_line;
                        mod_req.divisor  = {r_d, 1'b0};
                        n_state          = hsmg_pkg::ST_MODS;
                    end
                end
            end
            hsmg_pkg::ST_MODS: begin
                if (mod_rsp.done) begin
                    n_state = hsmg_pkg::ST_HOFF;
                end
            end
            hsmg_pkg::ST_HOFF: begin
                n_h     = hsmg_pkg::D_W'({1'b0, r_d} - dist_a);
                n_state = hsmg_pkg::ST_HNEG;
            end
            hsmg_pkg::ST_HNEG: begin
                n_hn          = hn_calc;
                n_step_ab     = (hdiff == '0) ? r_t : hdiff;
                n_step_ba     = r_t - hdiff;
                mod_req.start = 1'b1;
                n_state       = hsmg_pkg::ST_MODL;
            end
            hsmg_pkg::ST_MODL: begin
                if (mod_rsp.done) begin
                    n_state = hsmg_pkg::ST_FIRST;
                end
            end
            hsmg_pkg::ST_FIRST: begin
                n_word = r_left[hsmg_pkg::X_W-1:hsmg_pkg::WORD_W];
                n_mask = '0;
                if (r_t == '0) begin
                    n_mark  = hsmg_pkg::MARK_NONE;
                    n_phase = 1'b0;
                end else if (mod_rsp.rem <= h_ext) begin
                    n_mark  = {1'b0, base0} + {1'b0, h_ext};
                    n_phase = 1'b0;
                end else if (mod_rsp.rem <= r_hn) begin
                    n_mark  = {1'b0, base0} + {1'b0, r_hn};
                    n_phase = 1'b1;
                end else begin
                    n_mark  = {1'b0, base0} + {1'b0, r_t} + {2'b00, r_h};
                    n_phase = 1'b0;
                end
                n_state = hsmg_pkg::ST_WALK;
            end
            hsmg_pkg::ST_WALK: begin
                if (hit) begin
                    n_mask  = r_mask | (hsmg_pkg::MASK_W'(1) << r_mark[hsmg_pkg::WORD_W-1:0]);
                    n_mark  = r_mark + {1'b0, step_sel};
                    n_phase = !r_phase;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_base  = {r_word, {hsmg_pkg::WORD_W{1'b0}}};
                    n_out_mask  = r_mask;
                    n_out_line  = r_scan;
                    n_out_last  = is_last;
                    n_mask      = '0;
                    n_word      = r_word + hsmg_pkg::WORD_W'(1);
                    if (is_last) begin
                        n_state = hsmg_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = hsmg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsmg_pkg::ST_IDLE;
            r_d         <= hsmg_pkg::SPACING_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_d <= i_cfg.hatch_spacing;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_left     <= n_left;
        r_right    <= n_right;
        r_scan     <= n_scan;
        r_h        <= n_h;
        r_hn       <= n_hn;
        r_step_ab  <= n_step_ab;
        r_step_ba  <= n_step_ba;
        r_mark     <= n_mark;
        r_phase    <= n_phase;
        r_word     <= n_word;
        r_mask     <= n_mask;
        r_out_base <= n_out_base;
        r_out_mask <= n_out_mask;
        r_out_line <= n_out_line;
        r_out_last <= n_out_last;
    end

    assign o_word.valid       = r_out_valid;
    assign o_word.word_base_x = r_out_base;
    assign o_word.pixel_mask  = r_out_mask;
    assign o_word.line_echo   = r_out_line;
    assign o_word.last_word   = r_out_last;

    `HSMG_ASSERT_NOW(a_walk_mark_from_left, i_clk, i_rst_n,
        r_state == hsmg_pkg::ST_WALK, r_mark >= {1'b0, r_left},
        "Hatch point lies left of the span.")
    `HSMG_ASSERT_NOW(a_walk_word_in_span, i_clk, i_rst_n,
        r_state == hsmg_pkg::ST_WALK,
        (r_word >= r_left[hsmg_pkg::X_W-1:hsmg_pkg::WORD_W])
        && (r_word <= r_right[hsmg_pkg::X_W-1:hsmg_pkg::WORD_W]),
        "Mask word outside the span.")
    `HSMG_ASSERT_NOW(a_rem_done_in_wait, i_clk, i_rst_n,
        mod_rsp.done,
        (r_state == hsmg_pkg::ST_MODS || r_state == hsmg_pkg::ST_MODL)
        && (mod_rsp.rem < r_t),
        "Remainder finished outside a wait state or out of range.")
    `HSMG_ASSERT_NOW(a_walk_steps_nonzero, i_clk, i_rst_n,
        r_state == hsmg_pkg::ST_WALK && r_t != '0,
        r_step_ab != '0 && r_step_ba != '0,
        "Hatch walk step is zero.")
    `HSMG_ASSERT_NEXT(a_last_word_ends_span, i_clk, i_rst_n,
        r_state == hsmg_pkg::ST_WALK && !hit && out_free && is_last,
        r_state == hsmg_pkg::ST_IDLE && r_out_valid && r_out_last,
        "Last word did not end the span.")

endmodule

// ===== verif/tb.sv =====
// Testbench for the hatch span mask generator: directed and random spans against a predictor.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [hsmg_pkg::X_W-1:0]    base_x;
        logic [hsmg_pkg::MASK_W-1:0] mask;
        logic [hsmg_pkg::X_W-1:0]    line;
        logic                        last;
    } t_hatch_word;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hsmg_span_if span_ch();
    hsmg_cfg_if  cfg_ch();
    hsmg_word_if word_ch();

    hatch_span_mask_generator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_span  (span_ch),
        .i_cfg   (cfg_ch),
        .o_word  (word_ch)
    );

    t_hatch_word mask_q[$];
    t_hatch_word due;
    int unsigned spacing_now = 8;
    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 67;
    int unsigned hold_left = 0;
    logic        hold_req = 1'b0;
    int          fail_cnt = 0;
    int          span_cnt = 0;
    int          empty_cnt = 0;
    int          word_cnt = 0;
    int          spacing_writes = 0;
    int          cycle_cnt = 0;

    always #5 clk = ~clk;

    initial begin
        span_ch.valid = 1'b0;
        span_ch.x_left = '0;
        span_ch.x_right = '0;
        span_ch.scan_line = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.hatch_spacing = '0;
        word_ch.ready = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("hatch_span_mask_generator: mismatch");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (hold_req) begin
            hold_req <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            word_ch.ready <= 1'b0;
        end else begin
            word_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && word_ch.valid && word_ch.ready) begin
            if (mask_q.size() == 0) begin
                $error("unexpected mask word at base_x %0d", word_ch.word_base_x);
                fail_cnt++;
            end else begin
                due = mask_q.pop_front();
                word_cnt++;
                if (word_ch.word_base_x !== due.base_x) begin
                    $error("word_base_x: expected %0d, got %0d", due.base_x,
                           word_ch.word_base_x);
                    fail_cnt++;
                end
                if (word_ch.pixel_mask !== due.mask) begin
                    $error("pixel_mask: expected %h, got %h", due.mask, word_ch.pixel_mask);
                    fail_cnt++;
                end
                if (word_ch.line_echo !== due.line) begin
                    $error("line_echo: expected %0d, got %0d", due.line, word_ch.line_echo);
                    fail_cnt++;
                end
                if (word_ch.last_word !== due.last) begin
                    $error("last_word: expected %0b, got %0b", due.last, word_ch.last_word);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic void predict_words(int unsigned xl, int unsigned xr, int unsigned line);
        int unsigned period, off, off_neg, gap, rem, base, lo, hi;
        t_hatch_word hw;
        if (xl > xr)
            return;
        period = 2 * spacing_now;
        off = 0;
        off_neg = 0;
        if (period != 0) begin
            rem = line % period;
            gap = (rem >= spacing_now) ? rem - spacing_now : spacing_now - rem;
            off = spacing_now - gap;
            off_neg = (off == 0) ? 0 : period - off;
        end
        for (base = xl & ~32'd63; base <= xr; base += 64) begin
            hw.base_x = hsmg_pkg::X_W'(base);
            hw.mask = '0;
            hw.line = hsmg_pkg::X_W'(line);
            hw.last = (base + 64 > xr);
            lo = (xl > base) ? xl : base;
            hi = (xr < base + 63) ? xr : base + 63;
            if (period != 0) begin
                for (int unsigned x = lo; x <= hi; x++) begin
                    if ((x % period) == off || (x % period) == off_neg)
                        hw.mask[x - base] = 1'b1;
                end
            end
            mask_q.push_back(hw);
        end
    endfunction

    task automatic send_span(logic [hsmg_pkg::X_W-1:0] xl, logic [hsmg_pkg::X_W-1:0] xr,
                             logic [hsmg_pkg::X_W-1:0] line);
        while ($urandom_range(99) < send_idle_pct) begin
            span_ch.valid <= 1'b0;
            span_ch.x_left <= hsmg_pkg::X_W'($urandom);
            span_ch.x_right <= hsmg_pkg::X_W'($urandom);
            span_ch.scan_line <= hsmg_pkg::X_W'($urandom);
            @(posedge clk);
        end
        span_ch.valid <= 1'b1;
        span_ch.x_left <= xl;
        span_ch.x_right <= xr;
        span_ch.scan_line <= line;
        @(posedge clk);
        while (!span_ch.ready)
            @(posedge clk);
        predict_words(xl, xr, line);
        span_cnt++;
        if (xl > xr)
            empty_cnt++;
    endtask

    task automatic drain_words();
        span_ch.valid <= 1'b0;
        while (mask_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_spacing(logic [hsmg_pkg::D_W-1:0] value);
        drain_words();
        cfg_ch.valid <= 1'b1;
        cfg_ch.hatch_spacing <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        spacing_now = value;
        spacing_writes++;
    endtask

    task automatic random_span(output logic [hsmg_pkg::X_W-1:0] xl,
                               output logic [hsmg_pkg::X_W-1:0] xr,
                               output logic [hsmg_pkg::X_W-1:0] line);
        int unsigned kind, width, left;
        kind = $urandom_range(99);
        line = hsmg_pkg::X_W'($urandom);
        if (kind < 10) begin
            xr = hsmg_pkg::X_W'($urandom_range(4094, 0));
            xl = hsmg_pkg::X_W'($urandom_range(4095, xr + 1));
        end else if (kind < 18) begin
            xl = hsmg_pkg::X_W'($urandom);
            xr = hsmg_pkg::X_W'($urandom);
        end else begin
            left = $urandom_range(4095, 0);
            if (kind < 23)
                width = $urandom_range(4095, 0);
            else if ($urandom_range(1))
                width = $urandom_range(63, 0);
            else
                width = $urandom_range(320, 0);
            xl = hsmg_pkg::X_W'(left);
            xr = (left + width > 4095) ? hsmg_pkg::X_W'(4095) : hsmg_pkg::X_W'(left + width);
        end
    endtask

    function automatic logic [hsmg_pkg::D_W-1:0] random_spacing();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return hsmg_pkg::D_W'($urandom_range(24, 1));
        else if (pick < 80)
            return hsmg_pkg::D_W'($urandom_range(300, 25));
        return hsmg_pkg::D_W'($urandom_range(2047, 301));
    endfunction

    task automatic test_directed_spans();
        send_span(12'd0, 12'd4095, 12'd0);
        send_span(12'd0, 12'd0, 12'd0);
        send_span(12'd4095, 12'd4095, 12'd4095);
        send_span(12'd5, 12'd4, 12'd3);
        send_span(12'd4095, 12'd0, 12'd100);
        send_span(12'd63, 12'd64, 12'd7);
        send_span(12'd0, 12'd63, 12'd8);
        send_span(12'd64, 12'd127, 12'd16);
        send_span(12'd10, 12'd50, 12'd4095);
        send_span(12'd100, 12'd1000, 12'd12);
        send_span(12'd2048, 12'd4095, 12'd2731);
        send_span(12'd1, 12'd1, 12'd1);
    endtask

    task automatic test_spacing_extremes();
        write_spacing(hsmg_pkg::D_W'(0));
        send_span(12'd0, 12'd4095, 12'd5);
        send_span(12'd300, 12'd300, 12'd77);
        send_span(12'd700, 12'd100, 12'd1);
        write_spacing(hsmg_pkg::D_W'(1));
        send_span(12'd0, 12'd4095, 12'd0);
        send_span(12'd0, 12'd4095, 12'd1);
        send_span(12'd3, 12'd130, 12'd2);
        write_spacing(hsmg_pkg::D_W'(2047));
        send_span(12'd0, 12'd4095, 12'd2047);
        send_span(12'd0, 12'd4095, 12'd4094);
        send_span(12'd1, 12'd4095, 12'd4095);
        send_span(12'd2047, 12'd2047, 12'd0);
    endtask

    task automatic test_output_hold();
        int unsigned left;
        write_spacing(hsmg_pkg::D_W'(3));
        hold_req <= 1'b1;
        repeat (10) begin
            left = $urandom_range(3600, 0);
            send_span(hsmg_pkg::X_W'(left), hsmg_pkg::X_W'(left + $urandom_range(400, 64)),
                      hsmg_pkg::X_W'($urandom));
        end
        drain_words();
    endtask

    task automatic test_random_traffic(int n_spans, int unsigned s_idle, int unsigned r_idle);
        logic [hsmg_pkg::X_W-1:0] xl, xr, line;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n_spans; i++) begin
            if (i == 0 || i == n_spans / 2)
                write_spacing(random_spacing());
            random_span(xl, xr, line);
            send_span(xl, xr, line);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_spans();
        test_spacing_extremes();
        test_output_hold();
        test_random_traffic(84, 21, 67);
        test_random_traffic(84, 67, 21);
        test_random_traffic(84, 0, 0);
        drain_words();
        if (mask_q.size() != 0) begin
            $error("%0d mask words never arrived", mask_q.size());
            fail_cnt++;
        end
        $display("Sent %0d spans (%0d empty) and checked %0d mask words.", span_cnt, empty_cnt,
                 word_cnt);
        $display("The spacing was written %0d times, zero and both range ends included.",
                 spacing_writes);
        if (fail_cnt == 0)
            $display("hatch_span_mask_generator: match");
        else
            $display("hatch_span_mask_generator: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hsmg_pkg.sv
rtl/core/hsmg_span_if.sv
rtl/core/hsmg_word_if.sv
rtl/core/hsmg_cfg_if.sv
rtl/core/hsmg_mod_unit.sv
rtl/core/hatch_span_mask_generator.sv
verif/tb.sv
